### hdl/crc16_frame_deframer_defines.svh
// Assertion macros shared by the deframer checker.
// Macros expect signals named clk and rst in the scope where they are used.
`ifndef CRC16_FRAME_DEFRAMER_DEFINES_SVH
`define CRC16_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define CFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define CFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/cfd_pkg.sv
// Types, constants and the CRC-16/Modbus byte update for the frame deframer.
// Used by every RTL module and the checker.
package cfd_pkg;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 8;

  // byte positions in the frame header
  localparam logic [8:0] POS_START   = 9'd0;
  localparam logic [8:0] POS_VER_TYPE = 9'd1;
  localparam logic [8:0] POS_SRC_HI  = 9'd2;
  localparam logic [8:0] POS_SRC_LO  = 9'd3;
  localparam logic [8:0] POS_DST_HI  = 9'd4;
  localparam logic [8:0] POS_DST_LO  = 9'd5;
  localparam logic [8:0] POS_SEQ     = 9'd6;
  localparam logic [8:0] POS_LENGTH  = 9'd7;

  localparam logic [9:0] HEADER_BYTES = 10'd8;
  localparam logic [9:0] FRAME_MIN    = 10'd10;  // header plus two CRC bytes
  localparam logic [8:0] INDEX_MAX    = 9'd511;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_START_MARKER = 2'd0,
    REG_PROTO_VERSION = 2'd1,
    REG_HIGHEST_TYPE = 2'd2,
    REG_PAYLOAD_LIMIT = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_LENGTH  = 3'd1,
    ST_START   = 3'd2,
    ST_VERSION = 3'd3,
    ST_TYPE    = 3'd4,
    ST_CRC     = 3'd5
  } status_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } item_kind_t;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } beat_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  payload_byte;
    status_t     status;
    logic [3:0]  version;
    logic [3:0]  frame_type;
    logic [15:0] src_addr;
    logic [15:0] dst_addr;
    logic [7:0]  sequence_res;
    logic [7:0]  body_len;
  } result_t;

  // reflected CRC-16, one byte, eight shift steps
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### hdl/crc16_frame_deframer.sv
// Top level of the CRC-16/Modbus frame deframer.
// Instantiates cfd_in_stage, cfd_core and cfd_out_stage; depends on cfd_pkg.
//
//  channel   dir  handshake          payload
//  s_*       in   tvalid/tready      tdata[7:0] data_byte, tlast last_byte
//  m_*       out  tvalid/tready      tuser item_kind, tdata packed result fields
//  cfg_*     in   cfg_wr_en          cfg_addr register index, cfg_wdata value
//
// One byte beat per cycle while the master side is not stalled; a result passes
// through the input register, then the result register, after its byte is accepted.
// The CRC update is an unrolled eight-step byte update, computed combinationally.
// Synchronous reset restores register defaults and clears the frame state.
// A stalled master side holds the result; one more beat is buffered upstream.
module crc16_frame_deframer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [cfd_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] data_byte
  input  logic                             s_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [7:0] payload_byte, [10:8] status, [14:11] version, [18:15] frame_type,
  // [34:19] source address, [50:35] destination address, [58:51] sequence_res,
  // [66:59] declared payload length, [71:67] zero
  output logic [cfd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                             m_tuser,   // [0] item_kind
  input  logic                             cfg_wr_en,
  input  logic [cfd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import cfd_pkg::*;

  logic    beat_valid;
  beat_t   beat;
  logic    room;
  logic    fire;
  logic    res_valid;
  result_t res;

  assign fire = beat_valid && room;

  cfd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .take       (fire),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  cfd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  cfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res_valid (res_valid),
    .res       (res),
    .room      (room),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

### hdl/cfd_in_stage.sv
// Input register of the deframer: holds one byte beat until the parser takes it.
// Depends on cfd_pkg.
module cfd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [7:0]     s_tdata,
  input  logic           s_tlast,
  input  logic           take,
  output logic           beat_valid,
  output cfd_pkg::beat_t beat
);
  import cfd_pkg::*;

  // a held beat leaves in the same cycle it is taken, so a new one may enter
  assign s_tready = !beat_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      beat_valid <= 1'b1;
    end else if (take) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      beat.data <= s_tdata;
      beat.last <= s_tlast;
    end
  end

endmodule

### hdl/cfd_core.sv
// Frame parser: header capture, CRC accumulation, payload pass and end-of-frame check.
// Holds the configuration registers and the per-frame state. Depends on cfd_pkg.
module cfd_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [cfd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              fire,
  input  cfd_pkg::beat_t                    beat,
  output logic                              res_valid,
  output cfd_pkg::result_t                  res
);
  import cfd_pkg::*;

  logic [7:0]  start_marker;
  logic [3:0]  protocol_version;
  logic [3:0]  highest_frame_type;
  logic [7:0]  payload_limit;

  logic [8:0]  byte_index;
  logic [15:0] crc_acc;
  logic [15:0] rx_crc;
  logic        start_ok;
  logic [3:0]  hdr_version;
  logic [3:0]  hdr_type;
  logic [15:0] hdr_source;
  logic [15:0] hdr_dest;
  logic [7:0]  hdr_seq;
  logic [7:0]  hdr_len;

  logic        start_ok_next;
  logic [3:0]  hdr_version_next;
  logic [3:0]  hdr_type_next;
  logic [15:0] hdr_source_next;
  logic [15:0] hdr_dest_next;
  logic [7:0]  hdr_seq_next;
  logic [7:0]  hdr_len_next;
  logic [15:0] crc_acc_next;
  logic [15:0] rx_crc_next;
  logic [8:0]  byte_index_next;

  logic [9:0]  idx_w;
  logic [9:0]  body_end;
  logic        in_header;
  logic        in_payload;
  logic [9:0]  total;
  status_t     st;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker       <= 8'hAA;
      protocol_version   <= 4'd1;
      highest_frame_type <= 4'd4;
      payload_limit      <= 8'd32;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_START_MARKER:  start_marker       <= cfg_wdata;
        REG_PROTO_VERSION: protocol_version   <= cfg_wdata[3:0];
        REG_HIGHEST_TYPE:  highest_frame_type <= cfg_wdata[3:0];
        REG_PAYLOAD_LIMIT: payload_limit      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    start_ok_next    = start_ok;
    hdr_version_next = hdr_version;
    hdr_type_next    = hdr_type;
    hdr_source_next  = hdr_source;
    hdr_dest_next    = hdr_dest;
    hdr_seq_next     = hdr_seq;
    hdr_len_next     = hdr_len;
    case (byte_index)
      POS_START:    start_ok_next = (beat.data == start_marker);
      POS_VER_TYPE: begin
        hdr_version_next = beat.data[7:4];
        hdr_type_next    = beat.data[3:0];
      end
      POS_SRC_HI:   hdr_source_next = {beat.data, hdr_source[7:0]};
      POS_SRC_LO:   hdr_source_next = {hdr_source[15:8], beat.data};
      POS_DST_HI:   hdr_dest_next   = {beat.data, hdr_dest[7:0]};
      POS_DST_LO:   hdr_dest_next   = {hdr_dest[15:8], beat.data};
      POS_SEQ:      hdr_seq_next    = beat.data;
      POS_LENGTH:   hdr_len_next    = beat.data;
      default: ;
    endcase

    idx_w      = {1'b0, byte_index};
    body_end   = HEADER_BYTES + {2'b00, hdr_len_next};
    in_header  = idx_w < HEADER_BYTES;
    in_payload = !in_header && (idx_w < body_end);

    // CRC spans bytes 1 through the end of the payload
    if ((byte_index != POS_START) && (in_header || in_payload)) begin
      crc_acc_next = crc_byte(crc_acc, beat.data);
    end else begin
      crc_acc_next = crc_acc;
    end
    rx_crc_next = {rx_crc[7:0], beat.data};

    byte_index_next = (byte_index < INDEX_MAX) ? byte_index + 9'd1 : byte_index;

    total = idx_w + 10'd1;
    if (total < FRAME_MIN) begin
      st = ST_LENGTH;
    end else if (!start_ok_next) begin
      st = ST_START;
    end else if (hdr_version_next != protocol_version) begin
      st = ST_VERSION;
    end else if (hdr_type_next > highest_frame_type) begin
      st = ST_TYPE;
    end else if (hdr_len_next > payload_limit) begin
      st = ST_LENGTH;
    end else if (total != FRAME_MIN + {2'b00, hdr_len_next}) begin
      st = ST_LENGTH;
    end else if (crc_acc_next != rx_crc_next) begin
      st = ST_CRC;
    end else begin
      st = ST_OK;
    end

    res_valid = beat.last || in_payload;
    res       = '0;
    if (beat.last) begin
      res.kind         = KIND_STATUS;
      res.status       = st;
      res.version      = hdr_version_next;
      res.frame_type   = hdr_type_next;
      res.src_addr     = hdr_source_next;
      res.dst_addr     = hdr_dest_next;
      res.sequence_res = hdr_seq_next;
      res.body_len     = hdr_len_next;
    end else begin
      res.kind         = KIND_PAYLOAD;
      res.payload_byte = beat.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= '0;
      crc_acc     <= CRC_INIT;
      rx_crc      <= '0;
      start_ok    <= 1'b0;
      hdr_version <= '0;
      hdr_type    <= '0;
      hdr_source  <= '0;
      hdr_dest    <= '0;
      hdr_seq     <= '0;
      hdr_len     <= '0;
    end else if (fire) begin
      if (beat.last) begin
        byte_index  <= '0;
        crc_acc     <= CRC_INIT;
        rx_crc      <= '0;
        start_ok    <= 1'b0;
        hdr_version <= '0;
        hdr_type    <= '0;
        hdr_source  <= '0;
        hdr_dest    <= '0;
        hdr_seq     <= '0;
        hdr_len     <= '0;
      end else begin
        byte_index  <= byte_index_next;
        crc_acc     <= crc_acc_next;
        rx_crc      <= rx_crc_next;
        start_ok    <= start_ok_next;
        hdr_version <= hdr_version_next;
        hdr_type    <= hdr_type_next;
        hdr_source  <= hdr_source_next;
        hdr_dest    <= hdr_dest_next;
        hdr_seq     <= hdr_seq_next;
        hdr_len     <= hdr_len_next;
      end
    end
  end

endmodule

### hdl/cfd_out_stage.sv
// Result register of the deframer: packs one result item onto the master stream.
// Depends on cfd_pkg.
module cfd_out_stage (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic                             res_valid,
  input  cfd_pkg::result_t                 res,
  output logic                             room,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [cfd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  output logic                             m_tuser
);
  import cfd_pkg::*;

  // slot is free when empty or when its beat leaves this cycle
  assign room = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (room) begin
      m_tvalid <= load && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load && res_valid) begin
      m_tuser <= res.kind;
      m_tdata <= {5'b00000, res.body_len, res.sequence_res, res.dst_addr,
                  res.src_addr, res.frame_type, res.version, res.status,
                  res.payload_byte};
    end
  end

endmodule

### hdl/cfd_checker.sv
// Port-level checks on the deframer result stream, bound to the top level.
// Depends on cfd_pkg and crc16_frame_deframer_defines.svh.
`include "crc16_frame_deframer_defines.svh"

module cfd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [cfd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  input logic                             m_tuser
);
  import cfd_pkg::*;

  `CFD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

  `CFD_ASSERT_NOW(a_payload_clean, m_tvalid && (m_tuser == KIND_PAYLOAD), m_tdata[71:8] == '0, "payload beat carries header bits")

  `CFD_ASSERT_NOW(a_status_form, m_tvalid && (m_tuser == KIND_STATUS), (m_tdata[7:0] == 8'h00) && (m_tdata[10:8] <= ST_CRC) && (m_tdata[71:67] == 5'b00000), "malformed status beat")

  `CFD_ASSERT_NEXT(a_reset_empty, $fell(rst), !m_tvalid || $past(m_tvalid), "result appeared right after reset")

endmodule

bind crc16_frame_deframer cfd_checker u_cfd_checker (.*);
